// ===== sv/ibc_pkg.sv =====
`timescale 1ns / 1ps

package ibc_pkg;

  // Cascade size and number formats
  localparam int SECTIONS  = 11;
  localparam int NUM_TAPS  = 5;      // b0, b1, b2, a1, a2
  localparam int COEF_W    = 24;     // Q4.20
  localparam int COEF_FRAC = 20;
  localparam int W_W       = 32;     // Q8.24 section state
  localparam int SMP_W     = 16;     // Q1.15 samples
  localparam int IDX_W     = 6;
  localparam int SEC_W     = 4;      // section number decoded from a coefficient index
  localparam int IN_SHIFT  = 9;      // Q1.15 -> Q8.24
  localparam int PROD_W    = COEF_W + W_W;
  localparam int ACC_W     = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] W_MAX_ACC =
    {{(ACC_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] W_MIN_ACC =
    {{(ACC_W-W_W+1){1'b1}}, {(W_W-1){1'b0}}};
  localparam logic signed [W_W:0] Q_MAX = 33'sd32767;
  localparam logic signed [W_W:0] Q_MIN = -33'sd32768;
  localparam logic signed [W_W:0] TRUNC_BIAS = (33'sd1 <<< IN_SHIFT) - 33'sd1;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    K_B0 = 3'd0,
    K_B1 = 3'd1,
    K_B2 = 3'd2,
    K_A1 = 3'd3,
    K_A2 = 3'd4
  } coef_sel_t;

  // Per-section sequencer
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_A2,
    CS_W0,
    CS_B0,
    CS_B1,
    CS_B2,
    CS_Y
  } cell_state_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [SMP_W-1:0]  sample_in;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] filtered_out;
    logic signed [SMP_W-1:0] passthrough_out;
  } out_item_t;

  // Coefficient write bundle, one per section
  typedef struct packed {
    logic                     en;
    coef_sel_t                k;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  // Sample handed from one section to the next
  typedef struct packed {
    logic                  valid;
    logic signed [W_W-1:0] data;
  } beat_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // Q12.44 -> Q8.24, floor, saturated to 32 bits
  function automatic logic signed [W_W-1:0] rescale(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [W_W-1:0]   q;
    r = a >>> COEF_FRAC;
    if (r > W_MAX_ACC) begin
      q = W_MAX_ACC[W_W-1:0];
    end else if (r < W_MIN_ACC) begin
      q = W_MIN_ACC[W_W-1:0];
    end else begin
      q = r[W_W-1:0];
    end
    return q;
  endfunction

  // Q8.24 -> Q1.15, truncate toward zero, saturate
  function automatic logic signed [SMP_W-1:0] to_sample(input logic signed [W_W-1:0] y);
    logic signed [W_W:0] t;
    logic signed [W_W:0] q;
    logic signed [SMP_W-1:0] s;
    t = {y[W_W-1], y};
    if (y[W_W-1]) begin
      t = t + TRUNC_BIAS;
    end
    q = t >>> IN_SHIFT;
    if (q > Q_MAX) begin
      s = Q_MAX[SMP_W-1:0];
    end else if (q < Q_MIN) begin
      s = Q_MIN[SMP_W-1:0];
    end else begin
      s = q[SMP_W-1:0];
    end
    return s;
  endfunction

endpackage

// ===== sv/ibc_cell.sv =====
`timescale 1ns / 1ps

// One biquad section: own coefficients, own delay pair, one multiplier.
module ibc_cell import ibc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  coef_wr_t coef_wr,
  input  beat_t    x_in,
  output beat_t    y_out
);

  cell_state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] coef_r [NUM_TAPS];
  logic signed [W_W-1:0]    w1_r, w2_r, w0_r, y_r;
  logic                     y_valid_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [COEF_W-1:0] mul_c;
  logic signed [W_W-1:0]    mul_w;
  logic signed [W_W-1:0]    w0_nxt, y_nxt;
  logic                     load_w0, load_y;

  always_comb begin
    case (state_r)
      CS_IDLE: state_nxt = x_in.valid ? CS_A2 : CS_IDLE;
      CS_A2:   state_nxt = CS_W0;
      CS_W0:   state_nxt = CS_B0;
      CS_B0:   state_nxt = CS_B1;
      CS_B1:   state_nxt = CS_B2;
      CS_B2:   state_nxt = CS_Y;
      CS_Y:    state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    mul_c   = coef_r[K_A1];
    mul_w   = w1_r;
    acc_nxt = acc_r;
    w0_nxt  = w0_r;
    y_nxt   = y_r;
    load_w0 = 1'b0;
    load_y  = 1'b0;
    case (state_r)
      CS_IDLE: begin
        acc_nxt = ACC_W'(x_in.data) <<< COEF_FRAC;
      end
      CS_A2: begin
        mul_c   = coef_r[K_A2];
        mul_w   = w2_r;
        acc_nxt = sat_add(acc_r, -prod_ext);
      end
      CS_W0: begin
        w0_nxt  = rescale(sat_add(acc_r, -prod_ext));
        load_w0 = 1'b1;
      end
      CS_B0: begin
        mul_c = coef_r[K_B0];
        mul_w = w0_r;
      end
      CS_B1: begin
        mul_c   = coef_r[K_B1];
        mul_w   = w1_r;
        acc_nxt = prod_ext;
      end
      CS_B2: begin
        mul_c   = coef_r[K_B2];
        mul_w   = w2_r;
        acc_nxt = sat_add(acc_r, prod_ext);
      end
      CS_Y: begin
        y_nxt  = rescale(sat_add(acc_r, prod_ext));
        load_y = 1'b1;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  assign prod_nxt = mul_c * mul_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CS_IDLE;
      y_valid_r <= 1'b0;
      w1_r      <= '0;
      w2_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      y_valid_r <= load_y;
      if (load_y) begin
        w2_r <= w1_r;
        w1_r <= w0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (load_w0) begin
      w0_r <= w0_nxt;
    end
    if (load_y) begin
      y_r <= y_nxt;
    end
    if (coef_wr.en) begin
      coef_r[coef_wr.k] <= coef_wr.value;
    end
  end

  assign y_out.valid = y_valid_r;
  assign y_out.data  = y_r;

endmodule

// ===== sv/iir_biquad_cascade_df2.sv =====
`timescale 1ns / 1ps
// A sample beat is registered into x0_r and walks the chain one section at a time; each
// section works its steps on its one multiplier. The result waits in the last cell until
// the output register is free. No new sample is taken before that hand-off.
// Coefficient loads give no result beat.
// Reset (rst_n, synchronous, active low) clears delays, sequencers and handshake state;
// coefficients hold garbage until loaded.

module iir_biquad_cascade_df2 import ibc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Sequencing: one sample in flight. busy_r covers the walk through the chain and
  // the wait for a free output register; the output register itself is separate, so
  // a new sample can enter while the previous result still waits downstream.
  logic busy_r;
  logic done_r;
  logic out_valid_r;
  out_item_t out_data_r;
  logic signed [SMP_W-1:0] pass_r;
  beat_t x0_r;

  beat_t chain [SECTIONS+1];
  logic [SECTIONS:0] beat_vld;

  logic in_acc, smp_acc, ld_acc, out_take;

  // Coefficient index decode: section = idx / 5 via (idx * 13) >> 6, exact for 6-bit idx
  logic [IDX_W+SEC_W-1:0] idx_x13;
  logic [SEC_W-1:0]       sec;
  logic [IDX_W-1:0]       k_full;

  assign in_acc  = in_valid && in_ready;
  assign smp_acc = in_acc && (in_data.cmd == CMD_SAMPLE);
  assign ld_acc  = in_acc && (in_data.cmd == CMD_LOAD);

  assign idx_x13 = (IDX_W+SEC_W)'(in_data.coef_index) * (IDX_W+SEC_W)'(13);
  assign sec     = idx_x13[IDX_W+SEC_W-1:IDX_W];
  assign k_full  = in_data.coef_index - IDX_W'({2'b00, sec} * 6'd5);

  // Sample enters section 0 as Q8.24 in the cycle after its beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r.valid <= 1'b0;
    end else begin
      x0_r.valid <= smp_acc;
    end
    if (smp_acc) begin
      x0_r.data <= W_W'(in_data.sample_in) <<< IN_SHIFT;
      pass_r    <= in_data.sample_in;
    end
  end

  assign chain[0] = x0_r;

  // Section chain; loads go only to the section that the index names.
  // Indexes past the last section match no cell and are dropped.
  for (genvar s = 0; s < SECTIONS; s++) begin : g_sec
    coef_wr_t wr;
    assign wr.en    = ld_acc && (sec == SEC_W'(s));
    assign wr.k     = coef_sel_t'(k_full[2:0]);
    assign wr.value = in_data.coef_value;

    ibc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .coef_wr (wr),
      .x_in    (chain[s]),
      .y_out   (chain[s+1])
    );
  end

  for (genvar s = 0; s <= SECTIONS; s++) begin : g_vld
    assign beat_vld[s] = chain[s].valid;
  end

  // Result waits in the last cell until the output register is free
  assign out_take = done_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (smp_acc) begin
        busy_r <= 1'b1;
      end else if (out_take) begin
        busy_r <= 1'b0;
      end
      if (chain[SECTIONS].valid) begin
        done_r <= 1'b1;
      end else if (out_take) begin
        done_r <= 1'b0;
      end
      if (out_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r.filtered_out    <= to_sample(chain[SECTIONS].data);
      out_data_r.passthrough_out <= pass_r;
    end
  end

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Only one sample is ever moving through the chain
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({done_r, beat_vld}))
    else $error("more than one sample in the section chain");

  a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
    smp_acc |=> chain[0].valid)
    else $error("accepted sample did not enter section 0");

  a_last_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain[SECTIONS].valid |-> (busy_r && !done_r))
    else $error("cascade result without a pending sample");

  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |=> (out_valid_r && !busy_r && !done_r))
    else $error("result hand-off did not free the cascade");
`endif

endmodule

// ===== verif/tb_iir_biquad_cascade_df2.sv =====
`timescale 1ns / 1ps

module tb_iir_biquad_cascade_df2;
  import ibc_pkg::*;

  localparam int NCOEF       = SECTIONS * NUM_TAPS;   // coefficient words in the table
  localparam int LAT         = 7 * SECTIONS + 3;      // sample beat to result beat
  localparam int STALL_LIMIT = 25 * LAT;              // cycles with no beat on either side
  localparam int ONE_Q20     = 1 << COEF_FRAC;        // 1.0 in Q4.20
  localparam int A2_LIM      = 943718;                // 0.9 in Q4.20
  localparam int COEF_HI     = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_LO     = -(1 << (COEF_W - 1));
  localparam longint ACC_HI  = 64'sh7fff_ffff_ffff_ffff;
  localparam longint ACC_LO  = -64'sh7fff_ffff_ffff_ffff - 64'sd1;
  localparam longint Q824_HI = 64'sd2147483647;
  localparam longint Q824_LO = -64'sd2147483648;

  // Flavors of coefficient set for the random phases
  typedef enum int {
    SET_DAMPED,   // stable biquads, output stays in range
    SET_WILD,     // every word random over the full range
    SET_MIXED     // pass-through, extremes and random words mixed
  } coef_set_t;

  // One row of the directed part; known rows carry the expected filtered value
  typedef struct {
    in_item_t                beat;
    bit                      known;
    logic signed [SMP_W-1:0] known_out;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow copy of the filter: coefficients, delay lines, rotation phase
  longint coef_shadow [NCOEF];
  int     delay_shadow [3 * SECTIONS];
  int     rot_shadow;

  out_item_t pending_results [$];   // predicted results, oldest first
  dir_row_t  dir_rows [$];

  bit fresh_samples;    // a sample went in since the cascade last drained
  bit no_idle;          // closing phase: neither side idles
  int sender_odds;      // 0 = sender never idles, else one gap per this many beats
  int ready_hold;
  int stall_cycles;
  int results_seen;
  int err_count;

  iir_biquad_cascade_df2 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers for the shadow filter
  // ---------------------------------------------------------------------------

  // 64-bit add that clamps instead of wrapping; overflow shows in the top two bits
  function automatic longint add_clamp(input longint a, input longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? ACC_LO : ACC_HI;
    return s[63:0];
  endfunction

  // Q12.44 sum down to Q8.24: floor shift, then clamp to 32 bits
  function automatic longint q824_of(input longint acc);
    longint r;
    r = acc >>> COEF_FRAC;
    if (r > Q824_HI) r = Q824_HI;
    else if (r < Q824_LO) r = Q824_LO;
    return r;
  endfunction

  // Runs one sample through the shadow cascade and advances its state
  function automatic out_item_t cascade_predict(input logic signed [SMP_W-1:0] smp);
    out_item_t r;
    longint    w0, w1, w2, acc, q;
    int        x, cur, one, two, bc, bd;
    x   = int'(smp) <<< IN_SHIFT;   // Q1.15 -> Q8.24
    cur = rot_shadow;
    one = (cur + 2) % 3;            // slot written one sample back
    two = (cur + 1) % 3;            // slot written two samples back
    for (int s = 0; s < SECTIONS; s++) begin
      bc  = s * NUM_TAPS;
      bd  = s * 3;
      w1  = delay_shadow[bd + one];
      w2  = delay_shadow[bd + two];
      // w = x - a1*w1 - a2*w2
      acc = longint'(x) <<< COEF_FRAC;
      acc = add_clamp(acc, -(coef_shadow[bc + int'(K_A1)] * w1));
      acc = add_clamp(acc, -(coef_shadow[bc + int'(K_A2)] * w2));
      w0  = q824_of(acc);
      delay_shadow[bd + cur] = int'(w0);
      // y = b0*w + b1*w1 + b2*w2, feeds the next section
      acc = add_clamp(coef_shadow[bc + int'(K_B0)] * w0, coef_shadow[bc + int'(K_B1)] * w1);
      acc = add_clamp(acc, coef_shadow[bc + int'(K_B2)] * w2);
      x   = int'(q824_of(acc));
    end
    rot_shadow = (cur + 1) % 3;
    // back to Q1.15: divide truncates toward zero, then clip
    q = longint'(x) / longint'(1 << IN_SHIFT);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    r.filtered_out    = q[SMP_W-1:0];
    r.passthrough_out = smp;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t load_beat(input int idx, input int val);
    in_item_t b;
    b.cmd        = CMD_LOAD;
    b.sample_in  = 16'($urandom());   // ignored on loads
    b.coef_index = idx[IDX_W-1:0];
    b.coef_value = val[COEF_W-1:0];
    return b;
  endfunction

  function automatic dir_row_t mk_row(input cmd_t c, input int smp, input int idx,
                                      input int val, input bit known = 1'b0,
                                      input int res = 0);
    dir_row_t r;
    r.beat.cmd        = c;
    r.beat.sample_in  = smp[SMP_W-1:0];
    r.beat.coef_index = idx[IDX_W-1:0];
    r.beat.coef_value = val[COEF_W-1:0];
    r.known           = known;
    r.known_out       = res[SMP_W-1:0];
    return r;
  endfunction

  // Sender idle burst ahead of a beat, of random length
  function automatic int pick_gap();
    if (no_idle || sender_odds == 0) return 0;
    return ($urandom_range(1, sender_odds) == 1) ? $urandom_range(1, 17) : 0;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Drives one input beat and folds it into the shadow filter once accepted.
  // Called at a rising edge; leaves in_valid high so back-to-back beats don't glitch.
  task automatic send_beat(input in_item_t b, input int gap, input bit known,
                           input logic signed [SMP_W-1:0] known_out);
    out_item_t want;
    bit        reload;
    reload = (b.cmd == CMD_LOAD) && (b.coef_index < NCOEF) && fresh_samples;
    if (reload || gap > 0) begin
      in_valid <= 1'b0;
      if (reload) begin
        // coefficients only change with the cascade idle: drain, then let it settle
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LAT + 8) @(posedge clk);
        fresh_samples = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.cmd == CMD_LOAD) begin
      // out-of-range index is dropped
      if (b.coef_index < NCOEF) coef_shadow[b.coef_index] = longint'($signed(b.coef_value));
    end else begin
      want = cascade_predict(b.sample_in);
      if (known) want.filtered_out = known_out;
      pending_results.push_back(want);
      fresh_samples = 1'b1;
    end
  endtask

  // Loads all 55 words, section by section, with the odd out-of-range load mixed in
  task automatic load_coef_set(input coef_set_t flavor);
    int c [NUM_TAPS];
    int lim;
    for (int s = 0; s < SECTIONS; s++) begin
      case (flavor)
        SET_DAMPED: begin
          // poles inside the unit circle: |a2| < 0.9, |a1| < 0.94*(1 + a2)
          c[int'(K_A2)] = int'($urandom_range(0, 2 * A2_LIM)) - A2_LIM;
          lim           = ((ONE_Q20 + c[int'(K_A2)]) / 16) * 15;
          c[int'(K_A1)] = int'($urandom_range(0, 2 * lim)) - lim;
          c[int'(K_B0)] = ONE_Q20 / 2 + int'($urandom_range(0, ONE_Q20 / 2));
          c[int'(K_B1)] = int'($urandom_range(0, ONE_Q20 / 2)) - ONE_Q20 / 4;
          c[int'(K_B2)] = int'($urandom_range(0, ONE_Q20 / 2)) - ONE_Q20 / 4;
        end
        SET_WILD: begin
          for (int k = 0; k < NUM_TAPS; k++) c[k] = int'($urandom());
        end
        default: begin
          for (int k = 0; k < NUM_TAPS; k++) begin
            case ($urandom_range(0, 3))
              0:       c[k] = (k == int'(K_B0)) ? ONE_Q20 : 0;
              1:       c[k] = COEF_HI;
              2:       c[k] = COEF_LO;
              default: c[k] = int'($urandom());
            endcase
          end
        end
      endcase
      if ($urandom_range(0, 15) == 0)
        send_beat(load_beat($urandom_range(NCOEF, (1 << IDX_W) - 1), int'($urandom())),
                  pick_gap(), 1'b0, '0);
      for (int k = 0; k < NUM_TAPS; k++)
        send_beat(load_beat(s * NUM_TAPS + k, c[k]), pick_gap(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 16);    // stall of random length
    end else begin
      out_ready  <= 1'b1;
      // now and then a long stretch with no stall at all
      ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 40);
    end
  end

  // Result beat check against the oldest prediction, field by field
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result beat %0d arrived with nothing pending: %0d / %0d",
                             results_seen, $signed(out_data.filtered_out),
                             $signed(out_data.passthrough_out)));
      end else begin
        want = pending_results.pop_front();
        if (out_data.filtered_out !== want.filtered_out)
          flag_error($sformatf("result %0d filtered_out: expected %0d, got %0d",
                               results_seen, $signed(want.filtered_out),
                               $signed(out_data.filtered_out)));
        if (out_data.passthrough_out !== want.passthrough_out)
          flag_error($sformatf("result %0d passthrough_out: expected %0d, got %0d",
                               results_seen, $signed(want.passthrough_out),
                               $signed(out_data.passthrough_out)));
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every word gets written before the first sample; start as pure pass-through
    sender_odds = 3;
    for (int i = 0; i < NCOEF; i++)
      send_beat(load_beat(i, (i % NUM_TAPS == int'(K_B0)) ? ONE_Q20 : 0), pick_gap(),
                1'b0, '0);

    // Directed part. Unused fields carry junk on purpose.
    // pass-through cascade: output equals input
    dir_rows.push_back(mk_row(CMD_SAMPLE, 0,      63, COEF_HI, 1'b1, 0));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 32767,  0,  COEF_LO, 1'b1, 32767));
    dir_rows.push_back(mk_row(CMD_SAMPLE, -32768, 42, -1,      1'b1, -32768));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 1,      21, 1,       1'b1, 1));
    dir_rows.push_back(mk_row(CMD_SAMPLE, -1,     54, 12345,   1'b1, -1));
    // loads past the end of the table are dropped
    dir_rows.push_back(mk_row(CMD_LOAD, -1,    63,    COEF_HI));
    dir_rows.push_back(mk_row(CMD_LOAD, 32767, NCOEF, COEF_LO));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 12345, 0, 0, 1'b1, 12345));
    // first b0 at +8: output clips both ways
    dir_rows.push_back(mk_row(CMD_LOAD, -32768, int'(K_B0), COEF_HI));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 32767,  7, 7, 1'b1, 32767));
    dir_rows.push_back(mk_row(CMD_SAMPLE, -32768, 7, 7, 1'b1, -32768));
    // first b0 at -8: sign flips, still clipped
    dir_rows.push_back(mk_row(CMD_LOAD, 5, int'(K_B0), COEF_LO));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 32767,  9, 9, 1'b1, -32768));
    dir_rows.push_back(mk_row(CMD_SAMPLE, -32768, 9, 9, 1'b1, 32767));
    // feedback at the extremes drives the state into its 32-bit clamp
    dir_rows.push_back(mk_row(CMD_LOAD, 0, int'(K_A1), COEF_LO));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 32767, 1, 1));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 32767, 2, 2));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 32767, 3, 3));
    dir_rows.push_back(mk_row(CMD_LOAD, 0, int'(K_A2), COEF_HI));
    dir_rows.push_back(mk_row(CMD_LOAD, 0, NCOEF - 1,  COEF_HI));   // last section a2
    dir_rows.push_back(mk_row(CMD_SAMPLE, -32768, 4, 4));
    dir_rows.push_back(mk_row(CMD_SAMPLE, 0,      4, 4));
    dir_rows.push_back(mk_row(CMD_LOAD, 0, int'(K_B1), COEF_HI));
    dir_rows.push_back(mk_row(CMD_LOAD, 0, int'(K_B2), COEF_LO));
    dir_rows.push_back(mk_row(CMD_SAMPLE, -32768, 5, 5));
    foreach (dir_rows[i])
      send_beat(dir_rows[i].beat, pick_gap(), dir_rows[i].known, dir_rows[i].known_out);

    // Random phases: fresh coefficient set (loaded idle), then a sample stream.
    // Last phase runs with no idling on either side.
    for (int p = 0; p < 7; p++) begin
      no_idle     = (p == 6);
      sender_odds = (p % 3) * 2;
      load_coef_set(coef_set_t'(p % 3));
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(load_beat($urandom_range(NCOEF, (1 << IDX_W) - 1), int'($urandom())),
                    pick_gap(), 1'b0, '0);
        b.cmd        = CMD_SAMPLE;
        b.coef_index = 6'($urandom());
        b.coef_value = 24'($urandom());
        case ($urandom_range(0, 9))
          0:       b.sample_in = 16'sh7fff;
          1:       b.sample_in = 16'sh8000;
          2, 3, 4: b.sample_in = 16'($urandom_range(0, 1024) - 512);
          default: b.sample_in = 16'($urandom());
        endcase
        send_beat(b, pick_gap(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);   // catch any stray extra result beat
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
